/* sv/assert_macros.svh */
// Assertion helpers shared by the RTL that checks itself.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge while reset is released.
`define RH_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Checks that a condition implies a consequence in the same cycle.
`define RH_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication failed");

`endif

/* sv/rgbhsi_pkg.sv */
package rgbhsi_pkg;

    localparam int CORDIC_STEPS = 40;
    localparam int XY_W         = 44;
    localparam int ANG_W        = 40;
    localparam int REM_W        = 27;
    localparam int DIV_BITS     = 16;
    localparam logic [15:0] SAT_ONE = 16'd32768;

    // Unsigned long division, used only while elaborating constants.
    function automatic logic [63:0] udiv(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] rem;
        logic [63:0] q;
        rem = '0;
        q   = '0;
        for (int k = 63; k >= 0; k--) begin
            rem = {rem[63:0], a[k]};
            if (rem >= {1'b0, b}) begin
                rem  = rem - {1'b0, b};
                q[k] = 1'b1;
            end
        end
        return q;
    endfunction

    // atan(2^-i) in Q60 from its Taylor series, for i >= 1.
    function automatic logic signed [63:0] atan_pow2_q60(input int i);
        logic signed [63:0] sum;
        logic [63:0] term;
        logic        run;
        int          p;
        sum = '0;
        run = 1'b1;
        for (int k = 0; k < 64; k++) begin
            p = i * (2 * k + 1);
            if (p > 60) run = 1'b0;
            if (run) begin
                term = udiv(64'd1 << (60 - p), 64'(2 * k + 1));
                if (k % 2 == 1) sum = sum - $signed(term);
                else            sum = sum + $signed(term);
            end
        end
        return sum;
    endfunction

    // atan(1/3) in Q60.
    function automatic logic signed [63:0] atan_third_q60();
        logic signed [63:0] sum;
        logic [63:0] pw;
        logic [63:0] term;
        logic        run;
        sum = '0;
        pw  = 64'd3;
        run = 1'b1;
        for (int k = 0; k < 64; k++) begin
            if (run) begin
                term = udiv(udiv(64'd1 << 60, pw), 64'(2 * k + 1));
                if (term == 64'd0) begin
                    run = 1'b0;
                end else begin
                    if (k % 2 == 1) sum = sum - $signed(term);
                    else            sum = sum + $signed(term);
                    if (pw > udiv(64'd1 << 60, 64'd9)) run = 1'b0;
                    else pw = pw * 64'd9;
                end
            end
        end
        return sum;
    endfunction

    // round(a * 2^40 / b) by long division.
    function automatic logic [63:0] frac_turn(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] rem;
        logic [63:0] q;
        rem = a;
        q   = '0;
        for (int k = 0; k < 41; k++) begin
            rem = rem << 1;
            q   = q << 1;
            if (rem >= b) begin
                rem  = rem - b;
                q[0] = 1'b1;
            end
        end
        return (q + 64'd1) >> 1;
    endfunction

    // Angle of CORDIC step i in units of 2^-40 turn.
    function automatic logic [ANG_W-1:0] turn_step(input int i);
        logic [63:0] pi_q60;
        logic [63:0] res;
        pi_q60 = 64'd4 * 64'(atan_pow2_q60(1) + atan_third_q60());
        if (i == 0) res = 64'd1 << 37;
        else        res = frac_turn(64'(atan_pow2_q60(i)), 64'd2 * pi_q60);
        return res[ANG_W-1:0];
    endfunction

    function automatic logic [63:0] isqrt64(input logic [63:0] n_in);
        logic [63:0] n;
        logic [63:0] res;
        logic [63:0] bitv;
        n    = n_in;
        res  = '0;
        bitv = 64'd1 << 62;
        for (int k = 0; k < 32; k++) begin
            if (bitv > n) bitv = bitv >> 2;
        end
        for (int k = 0; k < 32; k++) begin
            if (bitv != 64'd0) begin
                if (n >= res + bitv) begin
                    n   = n - (res + bitv);
                    res = (res >> 1) + bitv;
                end else begin
                    res = res >> 1;
                end
                bitv = bitv >> 2;
            end
        end
        return res;
    endfunction

    localparam logic [63:0] SQRT3_FULL = isqrt64(64'd3 << 60);
    localparam logic [30:0] SQRT3_Q30  = SQRT3_FULL[30:0];

    typedef struct packed {
        logic signed [9:0] dx;
        logic signed [8:0] dgb;
        logic [9:0]        sum;
        logic [7:0]        mn;
        logic              gray;
    } prep_t;

    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic [ANG_W-1:0]       acc;
        logic [REM_W-1:0]       rem;
        logic [10:0]            den;
        logic [DIV_BITS-1:0]    q;
        logic                   black;
        logic                   gray;
        logic [9:0]             inten;
    } cord_t;

endpackage

/* sv/rgb_to_hsi_pixel_core.sv */
// RGB to HSI pixel converter.
// The input stream carries one pixel per request on s_axis: red in tdata[7:0],
// green in [15:8] and blue in [23:16]. The output stream m_axis carries hue in
// tdata[15:0] (fraction of a turn, 1/65536 units), saturation in [31:16]
// (Q1.15, 32768 is one) and intensity in [41:32] (channel sum).
// Throughput is one pixel per clock while m_axis is not stalled. A result
// passes through a preparation stage, a multiply stage, the 40 CORDIC
// vectoring stages of the hue path and the output register. Saturation uses a
// restoring divider, one quotient bit per stage, running alongside the first
// 16 CORDIC stages.
// The whole pipeline advances together. When the receiver holds tready low
// while a result is shown, every stage holds and s_axis_tready drops, so no
// request is lost or repeated. Reset clears all valid bits; the pipeline is
// empty and ready right after reset.
module rgb_to_hsi_pixel_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // red [7:0], green [15:8], blue [23:16]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata    // hue [15:0], saturation [31:16],
                                        // intensity [41:32], zero [47:42]
);

    localparam int NS = rgbhsi_pkg::CORDIC_STEPS;
    localparam int XW = rgbhsi_pkg::XY_W;
    localparam int AW = rgbhsi_pkg::ANG_W;
    localparam int RW = rgbhsi_pkg::REM_W;
    localparam int DB = rgbhsi_pkg::DIV_BITS;

    // Global advance: the output register is free or being emptied.
    logic en;

    logic [7:0] red, green, blue;

    rgbhsi_pkg::prep_t prep_next;
    rgbhsi_pkg::prep_t prep_reg;
    logic              prep_valid_reg;

    rgbhsi_pkg::cord_t c_next [NS+1];
    rgbhsi_pkg::cord_t c_reg  [NS+1];
    logic [NS:0]       c_valid_reg;

    logic [15:0] hue_next, sat_next;
    logic [15:0] hue_reg, sat_reg;
    logic [9:0]  inten_reg;
    logic        out_valid_reg;

    assign en            = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0, inten_reg, sat_reg, hue_reg};

    assign red   = s_axis_tdata[7:0];
    assign green = s_axis_tdata[15:8];
    assign blue  = s_axis_tdata[23:16];

    // Preparation: channel sum, minimum, the two color differences and the gray flag.
    always_comb
    begin
        logic [7:0] m;
        m = (red < green) ? red : green;
        if (blue < m) m = blue;
        prep_next.sum  = 10'(red) + 10'(green) + 10'(blue);
        prep_next.mn   = m;
        prep_next.dx   = $signed({2'b00, red} + {2'b00, red}) - $signed({2'b00, green})
                         - $signed({2'b00, blue});
        prep_next.dgb  = $signed({1'b0, green}) - $signed({1'b0, blue});
        prep_next.gray = (red == green) && (red == blue);
    end

    // Start vector: folded into the right half plane, y scaled by sqrt(3).
    always_comb
    begin
        logic              neg;
        logic [9:0]        xm;
        logic signed [8:0] ym;
        logic signed [40:0] prod;
        logic [9:0]        diff;
        neg  = prep_reg.dx[9];
        xm   = neg ? 10'(-prep_reg.dx) : 10'(prep_reg.dx);
        ym   = neg ? -prep_reg.dgb : prep_reg.dgb;
        prod = ym * $signed({1'b0, rgbhsi_pkg::SQRT3_Q30});
        diff = prep_reg.sum - 10'(3 * prep_reg.mn);
        c_next[0].x     = $signed({5'd0, xm[8:0], 30'd0});
        c_next[0].y     = XW'(prod);
        c_next[0].acc   = neg ? (AW'(1) << (AW - 1)) : '0;
        c_next[0].rem   = (RW'(diff) << 16) + RW'(prep_reg.sum);
        c_next[0].den   = {prep_reg.sum, 1'b0};
        c_next[0].q     = '0;
        c_next[0].black = (prep_reg.sum == 10'd0);
        c_next[0].gray  = prep_reg.gray;
        c_next[0].inten = prep_reg.sum;
    end

    // CORDIC vectoring stages; the first DB also resolve one quotient bit.
    for (genvar i = 0; i < NS; i++)
    begin : g_stage
        localparam logic [AW-1:0] TS = rgbhsi_pkg::turn_step(i);
        logic signed [XW-1:0] sx, sy;
        logic [RW-1:0]        rem_n;
        logic [DB-1:0]        q_n;

        assign sx = c_reg[i].y >>> i;
        assign sy = c_reg[i].x >>> i;

        if (i < DB)
        begin : g_div
            logic [RW-1:0] dsh;

            assign dsh = RW'(c_reg[i].den) << (DB - 1 - i);

            always_comb
            begin
                rem_n = c_reg[i].rem;
                q_n   = c_reg[i].q;
                if (c_reg[i].rem >= dsh)
                begin
                    rem_n             = c_reg[i].rem - dsh;
                    q_n[DB - 1 - i]   = 1'b1;
                end
            end
        end
        else
        begin : g_nodiv
            assign rem_n = c_reg[i].rem;
            assign q_n   = c_reg[i].q;
        end

        always_comb
        begin
            c_next[i+1] = c_reg[i];
            if (c_reg[i].y > 0)
            begin
                c_next[i+1].x   = c_reg[i].x + sx;
                c_next[i+1].y   = c_reg[i].y - sy;
                c_next[i+1].acc = c_reg[i].acc + TS;
            end
            else
            begin
                c_next[i+1].x   = c_reg[i].x - sx;
                c_next[i+1].y   = c_reg[i].y + sy;
                c_next[i+1].acc = c_reg[i].acc - TS;
            end
            c_next[i+1].rem = rem_n;
            c_next[i+1].q   = q_n;
        end
    end

    // Final rounding of the angle and the special cases.
    always_comb
    begin
        logic [AW-1:0] rnd;
        rnd      = c_reg[NS].acc + (AW'(1) << 23);
        hue_next = c_reg[NS].gray ? 16'd0 : rnd[AW-1:AW-16];
        sat_next = c_reg[NS].black ? rgbhsi_pkg::SAT_ONE : c_reg[NS].q;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prep_valid_reg <= 1'b0;
            c_valid_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else if (en)
        begin
            prep_valid_reg <= s_axis_tvalid;
            c_valid_reg    <= {c_valid_reg[NS-1:0], prep_valid_reg};
            out_valid_reg  <= c_valid_reg[NS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prep_reg <= prep_next;
            for (int k = 0; k <= NS; k++)
            begin
                c_reg[k] <= c_next[k];
            end
            hue_reg   <= hue_next;
            sat_reg   <= sat_next;
            inten_reg <= c_reg[NS].inten;
        end
    end

`include "assert_macros.svh"

    // A black pixel reports full saturation and zero hue.
    `RH_ASSERT_IMP(a_black, m_axis_tvalid && m_axis_tdata[41:32] == 10'd0,
                   m_axis_tdata[31:16] == 16'd32768 && m_axis_tdata[15:0] == 16'd0)
    // Saturation never exceeds one.
    `RH_ASSERT_IMP(a_sat_range, m_axis_tvalid, m_axis_tdata[31:16] <= 16'd32768)
    // A stalled result freezes the whole pipeline, input side included.
    `RH_ASSERT_IMP(a_stall, m_axis_tvalid && !m_axis_tready, !s_axis_tready)
    // A held result stays put while the receiver stalls.
    `RH_ASSERT(a_hold, (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps

module tb;

    localparam int LATENCY     = 42;
    localparam int CYCLE_LIMIT = 600000;

    // Laid out as on m_axis_tdata, lowest field last.
    typedef struct packed {
        logic [9:0]  inten;
        logic [15:0] sat;
        logic [15:0] hue;
    } hsi_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;   // red [7:0], green [15:8], blue [23:16]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;   // hue [15:0], saturation [31:16], intensity [41:32]

    rgb_to_hsi_pixel_core uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Conversion tables of the hue path: the CORDIC step angles in units of
    // 2^-40 turn and sqrt(3) in Q30.
    logic [63:0] step_angle [rgbhsi_pkg::CORDIC_STEPS];
    longint      root3_q30;

    hsi_t        pending_hsi[$];
    int          mismatches;
    int          pixels_sent;
    int          results_seen;
    longint      cycles;
    bit          idle_on;
    int          hold_cycles;
    int          ready_stall;

    // Arctangent of 2^-sh in Q60 by its Taylor series, each term truncated.
    function automatic longint atan_q60(input int sh);
        longint acc;
        int     p;
        acc = 0;
        for (int k = 0; k < 64; k++)
        begin
            p = sh * (2 * k + 1);
            if (p > 60)
                break;
            if (k % 2 == 1)
                acc -= longint'((64'd1 << (60 - p)) / (2 * k + 1));
            else
                acc += longint'((64'd1 << (60 - p)) / (2 * k + 1));
        end
        return acc;
    endfunction

    // Arctangent of 1/3 in Q60.
    function automatic longint atan_third();
        logic [63:0] pw;
        logic [63:0] term;
        longint      acc;
        pw  = 3;
        acc = 0;
        for (int k = 0; k < 64; k++)
        begin
            term = (64'd1 << 60) / pw / (2 * k + 1);
            if (term == 0)
                break;
            if (k % 2 == 1)
                acc -= longint'(term);
            else
                acc += longint'(term);
            if (pw > (64'd1 << 60) / 9)
                break;
            pw = pw * 9;
        end
        return acc;
    endfunction

    task automatic build_angle_tables();
        logic [63:0] full_turn;
        logic [63:0] rem;
        logic [63:0] quo;
        logic [63:0] root;
        full_turn = 64'd8 * 64'(atan_q60(1) + atan_third());
        step_angle[0] = 64'd1 << 37;
        for (int i = 1; i < rgbhsi_pkg::CORDIC_STEPS; i++)
        begin
            // Angle over a full turn, scaled by 2^40 and rounded half up.
            rem = 64'(atan_q60(i));
            quo = 0;
            for (int k = 0; k < 41; k++)
            begin
                rem = rem << 1;
                quo = quo << 1;
                if (rem >= full_turn)
                begin
                    rem    = rem - full_turn;
                    quo[0] = 1'b1;
                end
            end
            step_angle[i] = (quo + 1) >> 1;
        end
        root = 0;
        for (int b = 31; b >= 0; b--)
            if ((root | (64'd1 << b)) * (root | (64'd1 << b)) <= (64'd3 << 60))
                root = root | (64'd1 << b);
        root3_q30 = longint'(root);
    endtask

    function automatic hsi_t predict_hsi(input logic [7:0] r, input logic [7:0] g,
                                         input logic [7:0] b);
        hsi_t        res;
        longint      sum;
        longint      mn;
        longint      x;
        longint      y;
        longint      dx;
        longint      dy;
        logic [63:0] ang;
        sum = longint'(r) + longint'(g) + longint'(b);
        mn  = (r < g) ? r : g;
        if (b < mn)
            mn = b;
        res.inten = sum[9:0];
        if (sum == 0)
            res.sat = rgbhsi_pkg::SAT_ONE;
        else
            res.sat = 16'((2 * (sum - 3 * mn) * 32768 + sum) / (2 * sum));
        if (r == g && g == b)
        begin
            res.hue = 16'd0;
        end
        else
        begin
            x   = (2 * longint'(r) - longint'(g) - longint'(b)) * (longint'(1) << 30);
            y   = (longint'(g) - longint'(b)) * root3_q30;
            ang = 0;
            // Left half plane: rotate by half a turn first.
            if (x < 0)
            begin
                x   = -x;
                y   = -y;
                ang = 64'd1 << 39;
            end
            for (int i = 0; i < rgbhsi_pkg::CORDIC_STEPS; i++)
            begin
                dx = y >>> i;
                dy = x >>> i;
                if (y > 0)
                begin
                    x   = x + dx;
                    y   = y - dy;
                    ang = ang + step_angle[i];
                end
                else
                begin
                    x   = x - dx;
                    y   = y + dy;
                    ang = ang - step_angle[i];
                end
            end
            ang     = ang & ((64'd1 << 40) - 1);
            res.hue = 16'((ang + (64'd1 << 23)) >> 24);
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] %s: got %0d, want %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    // Offers one pixel and waits until the core takes it. A random idle burst
    // may follow; otherwise valid simply stays high for the next request.
    task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {b, g, r};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        pending_hsi.push_back(predict_hsi(r, g, b));
        pixels_sent++;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4))
                @(posedge clk);
        end
    endtask

    task automatic send_random_pixel();
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        r = $urandom;
        g = $urandom;
        b = $urandom;
        // Now and then force near-gray or tied channels, where hue is touchy.
        case ($urandom_range(0, 5))
            0: g = r;
            1: b = g;
            2: begin g = r; b = 8'(r + $urandom_range(0, 2) - 1); end
            default: ;
        endcase
        send_pixel(r, g, b);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_hsi.size() != 0)
            @(posedge clk);
    endtask

    // Black, white, grays, primaries, secondaries and the hue wrap point.
    task automatic test_corner_pixels();
        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd1, 8'd1, 8'd1);
        send_pixel(8'd128, 8'd128, 8'd128);
        send_pixel(8'd255, 8'd0, 8'd0);
        send_pixel(8'd0, 8'd255, 8'd0);
        send_pixel(8'd0, 8'd0, 8'd255);
        send_pixel(8'd255, 8'd255, 8'd0);
        send_pixel(8'd0, 8'd255, 8'd255);
        send_pixel(8'd255, 8'd0, 8'd255);
        send_pixel(8'd255, 8'd0, 8'd1);
        send_pixel(8'd255, 8'd1, 8'd0);
        send_pixel(8'd1, 8'd0, 8'd0);
        send_pixel(8'd0, 8'd0, 8'd1);
        send_pixel(8'd0, 8'd1, 8'd1);
        send_pixel(8'd254, 8'd255, 8'd255);
        send_pixel(8'd255, 8'd254, 8'd254);
        send_pixel(8'd170, 8'd85, 8'd0);
        send_pixel(8'd0, 8'd128, 8'd128);
        send_pixel(8'd85, 8'd170, 8'd255);
        wait_drained();
    endtask

    task automatic test_random_pixels(input int count);
        repeat (count)
            send_random_pixel();
    endtask

    // The receiver holds off long enough for the pipeline to fill and push
    // back on the input, while the sender keeps offering pixels.
    task automatic test_output_hold();
        hold_cycles = 150;
        repeat (80)
            send_random_pixel();
        wait_drained();
    endtask

    // Back-to-back pixels with neither side idling.
    task automatic test_full_rate(input int count);
        idle_on = 1'b0;
        repeat (count)
            send_random_pixel();
        wait_drained();
    endtask

    initial
    begin
        clk = 1'b0;
        forever
            #4 clk = ~clk;
    end

    // Receiver: drives tready with random stall bursts and checks every result.
    always @(posedge clk)
    begin
        hsi_t want;
        hsi_t got;
        cycles <= cycles + 1;
        if (m_axis_tvalid && m_axis_tready && rst_n)
        begin
            got = m_axis_tdata[41:0];
            results_seen++;
            if (pending_hsi.size() == 0)
            begin
                report_mismatch("result with no pixel pending", 0, 0);
            end
            else
            begin
                want = pending_hsi.pop_front();
                if (got.hue != want.hue)
                    report_mismatch("hue", got.hue, want.hue);
                if (got.sat != want.sat)
                    report_mismatch("saturation", got.sat, want.sat);
                if (got.inten != want.inten)
                    report_mismatch("intensity", got.inten, want.inten);
            end
        end
        if (hold_cycles > 0)
        begin
            m_axis_tready <= 1'b0;
            hold_cycles   <= hold_cycles - 1;
        end
        else if (ready_stall > 0)
        begin
            m_axis_tready <= 1'b0;
            ready_stall   <= ready_stall - 1;
        end
        else if (idle_on && $urandom_range(0, 4) == 0)
        begin
            m_axis_tready <= 1'b0;
            ready_stall   <= $urandom_range(0, 3);
        end
        else
        begin
            m_axis_tready <= 1'b1;
        end
    end

    initial
    begin
        @(posedge clk);
        while (cycles < CYCLE_LIMIT)
            @(posedge clk);
        $display("Timeout after %0d cycles, %0d results outstanding", cycles,
                 pending_hsi.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        mismatches    = 0;
        pixels_sent   = 0;
        results_seen  = 0;
        cycles        = 0;
        idle_on       = 1'b1;
        hold_cycles   = 0;
        ready_stall   = 0;
        build_angle_tables();
        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_corner_pixels();
        test_random_pixels(500);
        // The sender pauses here until every result is back.
        wait_drained();
        test_output_hold();
        test_random_pixels(400);
        test_full_rate(250);

        repeat (LATENCY + 10)
            @(posedge clk);
        if (pending_hsi.size() != 0)
            report_mismatch("results never returned", 0, pending_hsi.size());
        $display("Converted %0d pixels (%0d results checked): corner colors, random and",
                 pixels_sent, results_seen);
        $display("near-gray pixels, idle bursts, a long output hold and full-rate flow.");
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
